@@ hw/rtl/asm_pkg.sv @@
// Package for the allocation statistics monitor: widths, opcodes, structs
// and the small helper functions shared by the RTL files. No dependencies.
`timescale 1ns / 1ps

package asm_pkg;

  localparam int unsigned BYTE_W       = 48;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned REG_W        = 2;
  localparam int unsigned BIN_W        = 4;
  localparam int unsigned BIN_COUNT    = 10;
  localparam int unsigned REGION_COUNT = 3;
  localparam int unsigned HIST_DEPTH   = REGION_COUNT * BIN_COUNT;
  localparam int unsigned HIST_AW      = $clog2(HIST_DEPTH);
  localparam int unsigned LIMIT_W      = 11;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_RESIZE     = 3'd2,
    OP_ENTER      = 3'd3,
    OP_EXIT       = 3'd4,
    OP_PEAK_RESET = 3'd5,
    OP_READ_BIN   = 3'd6,
    OP_NOP        = 3'd7
  } opcode_e;

  localparam logic [REG_W-1:0] REGION_SEQ   = 2'd0;
  localparam logic [REG_W-1:0] REGION_PAR   = 2'd1;
  localparam logic [REG_W-1:0] REGION_TRANS = 2'd2;

  typedef logic [LIMIT_W-1:0] limit_t;

  // Lower bound of every histogram bin above the first one.
  localparam limit_t BIN_LIMIT [BIN_COUNT-1] = '{
    11'd17, 11'd33, 11'd49, 11'd65, 11'd97, 11'd129, 11'd257, 11'd513, 11'd1025
  };

  typedef struct packed {
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] peak;
    logic [BYTE_W-1:0] total;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  live_peak;
    logic [CNT_W-1:0]  alloc_seq;
    logic [CNT_W-1:0]  alloc_par;
    logic [CNT_W-1:0]  alloc_trans;
    logic [CNT_W-1:0]  free_seq;
    logic [CNT_W-1:0]  free_par;
    logic [CNT_W-1:0]  free_trans;
    logic [BYTE_W-1:0] region_bytes;
    logic [REG_W-1:0]  region_now;
  } snap_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
  } hist_access_t;

  typedef struct packed {
    logic [BYTE_W-1:0] current_bytes;
    logic [BYTE_W-1:0] peak_bytes;
    logic [BYTE_W-1:0] total_bytes;
    logic [CNT_W-1:0]  live_count;
    logic [CNT_W-1:0]  live_peak;
    logic [CNT_W-1:0]  seq_par_allocs;
    logic [CNT_W-1:0]  seq_par_frees;
    logic [CNT_W-1:0]  trans_allocs;
    logic [CNT_W-1:0]  trans_frees;
    logic [CNT_W-1:0]  bin_count;
    logic [BYTE_W-1:0] region_bytes;
    logic [REG_W-1:0]  region_now;
  } out_t;

  function automatic logic [BYTE_W-1:0] sat_add48(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] a);
    return (a == {CNT_W{1'b1}}) ? a : a + CNT_W'(1);
  endfunction

  // The fourth region code is taken as transactional.
  function automatic logic [REG_W-1:0] map_region(input logic [REG_W-1:0] r);
    return (r == 2'd3) ? REGION_TRANS : r;
  endfunction

  function automatic logic [BIN_W-1:0] size_bin(input logic [BYTE_W-1:0] size);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int i = 0; i < BIN_COUNT - 1; i++) begin
      if (size >= BYTE_W'(BIN_LIMIT[i])) begin
        b = BIN_W'(i + 1);
      end
    end
    return b;
  endfunction

  function automatic logic [HIST_AW-1:0] hist_addr(input logic [REG_W-1:0] region,
                                                   input logic [BIN_W-1:0] bin);
    return HIST_AW'(region) * HIST_AW'(BIN_COUNT) + HIST_AW'(bin);
  endfunction

endpackage

@@ hw/rtl/asm_evt_if.sv @@
// Event channel of the allocation statistics monitor: valid/ready and the
// event fields. Depends on asm_pkg.
`timescale 1ns / 1ps

interface asm_evt_if import asm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] new_size;
  logic [BYTE_W-1:0] old_size;
  logic [REG_W-1:0]  region_select;
  logic [BIN_W-1:0]  bin_select;

  modport source (output valid, opcode, new_size, old_size, region_select, bin_select,
                  input ready);
  modport sink (input valid, opcode, new_size, old_size, region_select, bin_select,
                output ready);
endinterface

@@ hw/rtl/asm_snap_if.sv @@
// Snapshot channel of the allocation statistics monitor: valid/ready and the
// counter snapshot fields. Depends on asm_pkg.
`timescale 1ns / 1ps

interface asm_snap_if import asm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] current_bytes;
  logic [BYTE_W-1:0] peak_bytes;
  logic [BYTE_W-1:0] total_bytes;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  live_peak;
  logic [CNT_W-1:0]  seq_par_allocs;
  logic [CNT_W-1:0]  seq_par_frees;
  logic [CNT_W-1:0]  trans_allocs;
  logic [CNT_W-1:0]  trans_frees;
  logic [CNT_W-1:0]  bin_count;
  logic [BYTE_W-1:0] region_bytes;
  logic [REG_W-1:0]  region_now;

  modport source (output valid, current_bytes, peak_bytes, total_bytes, live_count,
                  live_peak, seq_par_allocs, seq_par_frees, trans_allocs, trans_frees,
                  bin_count, region_bytes, region_now,
                  input ready);
  modport sink (input valid, current_bytes, peak_bytes, total_bytes, live_count,
                live_peak, seq_par_allocs, seq_par_frees, trans_allocs, trans_frees,
                bin_count, region_bytes, region_now,
                output ready);
endinterface

@@ hw/rtl/asm_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module asm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/asm_hist.sv @@
// Size histogram of the monitor: a RAM of saturating counters with valid bits,
// read-modify-write with one-deep forwarding. Depends on asm_pkg and asm_ram.
`timescale 1ns / 1ps

module asm_hist import asm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hist_access_t     lookup_i,
  input  hist_access_t     update_i,
  output logic [CNT_W-1:0] count_o
);

  logic [HIST_DEPTH-1:0] vld_q;
  logic                  hit_q;
  logic                  seen_q;
  logic [CNT_W-1:0]      fwd_q;
  logic [CNT_W-1:0]      rdata;
  logic [CNT_W-1:0]      wdata;

  asm_ram #(
    .WIDTH(CNT_W),
    .DEPTH(HIST_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (update_i.en),
    .waddr_i(update_i.addr),
    .wdata_i(wdata),
    .re_i   (lookup_i.en),
    .raddr_i(lookup_i.addr),
    .rdata_o(rdata)
  );

  // A lookup issued in the same cycle as a write to that entry reads stale
  // data, so the written value is captured alongside it and used instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      hit_q  <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      if (update_i.en) begin
        vld_q[update_i.addr] <= 1'b1;
      end
      if (lookup_i.en) begin
        hit_q  <= update_i.en && (update_i.addr == lookup_i.addr);
        seen_q <= vld_q[lookup_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_i.en) begin
      fwd_q <= wdata;
    end
  end

  assign count_o = hit_q ? fwd_q : (seen_q ? rdata : '0);
  assign wdata   = sat_inc32(count_o);

endmodule

@@ hw/rtl/asm_stats.sv @@
// Scalar and per-region counters of the monitor and the region stack.
// Produces the post-event snapshot of every counter. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_stats import asm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ev_en_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [BYTE_W-1:0] new_size_i,
  input  logic [BYTE_W-1:0] old_size_i,
  input  logic [REG_W-1:0]  region_select_i,
  output logic [REG_W-1:0]  active_o,
  output snap_t             snap_o
);

  logic [BYTE_W-1:0] cur_q, cur_d, cur_f;
  logic [BYTE_W-1:0] peak_q, peak_d;
  logic [BYTE_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]  live_q, live_d, live_f;
  logic [CNT_W-1:0]  lpeak_q, lpeak_d;
  logic [CNT_W-1:0]  alloc_q [REGION_COUNT];
  logic [CNT_W-1:0]  alloc_d [REGION_COUNT];
  logic [CNT_W-1:0]  free_q [REGION_COUNT];
  logic [CNT_W-1:0]  free_d [REGION_COUNT];
  logic [BYTE_W-1:0] bytes_q [REGION_COUNT];
  logic [BYTE_W-1:0] bytes_d [REGION_COUNT];
  logic [REG_W-1:0]  active_q, active_d;
  logic [REG_W-1:0]  saved_q, saved_d;
  opcode_e           op;
  logic              is_free;
  logic              is_alloc;

  assign op       = opcode_e'(opcode_i);
  assign is_free  = (op == OP_FREE) || (op == OP_RESIZE);
  assign is_alloc = ((op == OP_ALLOC) || (op == OP_RESIZE)) && (new_size_i != '0);

  // A resize is a free followed by an alloc, so the alloc works on the
  // values that the free leaves.
  always_comb begin
    cur_f  = is_free ? ((old_size_i > cur_q) ? '0 : cur_q - old_size_i) : cur_q;
    live_f = (is_free && (live_q != '0)) ? live_q - CNT_W'(1) : live_q;
    cur_d   = is_alloc ? sat_add48(cur_f, new_size_i) : cur_f;
    total_d = is_alloc ? sat_add48(total_q, new_size_i) : total_q;
    live_d  = is_alloc ? sat_inc32(live_f) : live_f;
    lpeak_d = (is_alloc && (live_d > lpeak_q)) ? live_d : lpeak_q;
    if (op == OP_PEAK_RESET) begin
      peak_d = cur_q;
    end else if (is_alloc && (cur_d > peak_q)) begin
      peak_d = cur_d;
    end else begin
      peak_d = peak_q;
    end
    for (int r = 0; r < REGION_COUNT; r++) begin
      alloc_d[r] = (is_alloc && (active_q == REG_W'(r))) ? sat_inc32(alloc_q[r]) : alloc_q[r];
      free_d[r]  = (is_free && (active_q == REG_W'(r))) ? sat_inc32(free_q[r]) : free_q[r];
      bytes_d[r] = (is_alloc && (active_q == REG_W'(r))) ?
                   sat_add48(bytes_q[r], new_size_i) : bytes_q[r];
    end
  end

  always_comb begin
    active_d = active_q;
    saved_d  = saved_q;
    case (op)
      OP_ENTER: begin
        saved_d  = active_q;
        active_d = map_region(region_select_i);
      end
      OP_EXIT: begin
        active_d = saved_q;
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      peak_q   <= '0;
      total_q  <= '0;
      live_q   <= '0;
      lpeak_q  <= '0;
      active_q <= REGION_SEQ;
      saved_q  <= REGION_SEQ;
      for (int r = 0; r < REGION_COUNT; r++) begin
        alloc_q[r] <= '0;
        free_q[r]  <= '0;
        bytes_q[r] <= '0;
      end
    end else if (ev_en_i) begin
      cur_q    <= cur_d;
      peak_q   <= peak_d;
      total_q  <= total_d;
      live_q   <= live_d;
      lpeak_q  <= lpeak_d;
      active_q <= active_d;
      saved_q  <= saved_d;
      for (int r = 0; r < REGION_COUNT; r++) begin
        alloc_q[r] <= alloc_d[r];
        free_q[r]  <= free_d[r];
        bytes_q[r] <= bytes_d[r];
      end
    end
  end

  assign active_o = active_q;

  always_comb begin
    snap_o.cur          = cur_d;
    snap_o.peak         = peak_d;
    snap_o.total        = total_d;
    snap_o.live         = live_d;
    snap_o.live_peak    = lpeak_d;
    snap_o.alloc_seq    = alloc_d[REGION_SEQ];
    snap_o.alloc_par    = alloc_d[REGION_PAR];
    snap_o.alloc_trans  = alloc_d[REGION_TRANS];
    snap_o.free_seq     = free_d[REGION_SEQ];
    snap_o.free_par     = free_d[REGION_PAR];
    snap_o.free_trans   = free_d[REGION_TRANS];
    snap_o.region_bytes = (op == OP_READ_BIN) ? bytes_q[map_region(region_select_i)] : '0;
    snap_o.region_now   = active_d;
  end

endmodule

@@ hw/rtl/allocation_statistics_monitor_top.sv @@
// Allocation statistics monitor, top level: event channel in, snapshot out.
// Depends on asm_pkg, asm_evt_if, asm_snap_if, asm_stats and asm_hist.
`timescale 1ns / 1ps

// The monitor takes one allocation event per clock cycle unless the output
// stalls, and returns one snapshot transaction per event, in order, through
// the s1 stage and output registers. The scalar and per-region counters
// update in the cycle of acceptance; the size histogram lives in a RAM with a
// registered read, so its read-modify-write reads in the acceptance cycle and
// writes back as the event leaves s1, with forwarding between back-to-back
// updates of the same bin. Histogram bins are tracked by valid bits cleared at
// reset, so the block is ready immediately after reset with no clearing pass.

module allocation_statistics_monitor_top import asm_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  asm_evt_if.sink     evt_i,
  asm_snap_if.source  snap_o
);

  logic             in_acc;
  logic             s1_adv;
  logic             s1_vld_q;
  snap_t            s1_snap_q;
  logic             s1_inc_q;
  logic             s1_rd_q;
  logic [HIST_AW-1:0] s1_addr_q;
  logic             out_vld_q;
  out_t             out_q;
  snap_t            snap;
  logic [REG_W-1:0] active;
  opcode_e          op;
  logic             lk_inc;
  logic             lk_rd;
  logic [HIST_AW-1:0] lk_addr;
  hist_access_t     lookup;
  hist_access_t     update;
  logic [CNT_W-1:0] hist_count;

  assign op     = opcode_e'(evt_i.opcode);
  assign s1_adv = s1_vld_q && (!out_vld_q || snap_o.ready);
  assign evt_i.ready = !s1_vld_q || s1_adv;
  assign in_acc = evt_i.valid && evt_i.ready;

  asm_stats u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ev_en_i        (in_acc),
    .opcode_i       (evt_i.opcode),
    .new_size_i     (evt_i.new_size),
    .old_size_i     (evt_i.old_size),
    .region_select_i(evt_i.region_select),
    .active_o       (active),
    .snap_o         (snap)
  );

  // Allocations bump the bin of the region active before the event; a bin
  // read outside the ten bins needs no lookup and returns zero.
  always_comb begin
    lk_inc = ((op == OP_ALLOC) || (op == OP_RESIZE)) && (evt_i.new_size != '0);
    lk_rd  = (op == OP_READ_BIN) && (evt_i.bin_select < BIN_W'(BIN_COUNT));
    if (lk_inc) begin
      lk_addr = hist_addr(active, size_bin(evt_i.new_size));
    end else begin
      lk_addr = hist_addr(map_region(evt_i.region_select), evt_i.bin_select);
    end
    lookup.en   = in_acc && (lk_inc || lk_rd);
    lookup.addr = lk_addr;
    update.en   = s1_adv && s1_inc_q;
    update.addr = s1_addr_q;
  end

  asm_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .lookup_i(lookup),
    .update_i(update),
    .count_o (hist_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (snap_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_snap_q <= snap;
      s1_inc_q  <= lk_inc;
      s1_rd_q   <= lk_rd;
      s1_addr_q <= lk_addr;
    end
    if (s1_adv) begin
      out_q.current_bytes  <= s1_snap_q.cur;
      out_q.peak_bytes     <= s1_snap_q.peak;
      out_q.total_bytes    <= s1_snap_q.total;
      out_q.live_count     <= s1_snap_q.live;
      out_q.live_peak      <= s1_snap_q.live_peak;
      out_q.seq_par_allocs <= sat_add32(s1_snap_q.alloc_seq, s1_snap_q.alloc_par);
      out_q.seq_par_frees  <= sat_add32(s1_snap_q.free_seq, s1_snap_q.free_par);
      out_q.trans_allocs   <= s1_snap_q.alloc_trans;
      out_q.trans_frees    <= s1_snap_q.free_trans;
      out_q.bin_count      <= s1_rd_q ? hist_count : '0;
      out_q.region_bytes   <= s1_snap_q.region_bytes;
      out_q.region_now     <= s1_snap_q.region_now;
    end
  end

  assign snap_o.valid          = out_vld_q;
  assign snap_o.current_bytes  = out_q.current_bytes;
  assign snap_o.peak_bytes     = out_q.peak_bytes;
  assign snap_o.total_bytes    = out_q.total_bytes;
  assign snap_o.live_count     = out_q.live_count;
  assign snap_o.live_peak      = out_q.live_peak;
  assign snap_o.seq_par_allocs = out_q.seq_par_allocs;
  assign snap_o.seq_par_frees  = out_q.seq_par_frees;
  assign snap_o.trans_allocs   = out_q.trans_allocs;
  assign snap_o.trans_frees    = out_q.trans_frees;
  assign snap_o.bin_count      = out_q.bin_count;
  assign snap_o.region_bytes   = out_q.region_bytes;
  assign snap_o.region_now     = out_q.region_now;

endmodule

@@ hw/rtl/asm_chk.sv @@
// Port-level checker for the allocation statistics monitor and its bind to
// the top level. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_chk import asm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] current_bytes_i,
  input logic [BYTE_W-1:0] peak_bytes_i,
  input logic [BYTE_W-1:0] total_bytes_i,
  input logic [CNT_W-1:0]  live_count_i,
  input logic [CNT_W-1:0]  live_peak_i,
  input logic [REG_W-1:0]  region_now_i
);

  logic              out_acc;
  logic              seen_q;
  logic [BYTE_W-1:0] last_total_q;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_total_q <= '0;
    end else if (out_acc) begin
      seen_q       <= 1'b1;
      last_total_q <= total_bytes_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("snapshot valid dropped before the transaction completed");

  a_peak_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> peak_bytes_i >= current_bytes_i)
    else $error("peak bytes below current bytes");

  a_live_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> live_peak_i >= live_count_i)
    else $error("live peak below live count");

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> total_bytes_i >= last_total_q)
    else $error("total bytes decreased between snapshots");

  a_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> region_now_i != 2'd3)
    else $error("active region out of range");

endmodule

bind allocation_statistics_monitor_top asm_chk u_asm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (snap_o.valid),
  .out_ready_i    (snap_o.ready),
  .current_bytes_i(snap_o.current_bytes),
  .peak_bytes_i   (snap_o.peak_bytes),
  .total_bytes_i  (snap_o.total_bytes),
  .live_count_i   (snap_o.live_count),
  .live_peak_i    (snap_o.live_peak),
  .region_now_i   (snap_o.region_now)
);
